FILE: rtl/core/npp_pkg.sv
`timescale 1ns / 1ps
// shared constants, codes and controller/datapath structs for the disk placement block
// no dependencies

package npp_pkg;

   localparam int CAPACITY   = 1024;
   localparam int COORD_BITS = 24;
   localparam int IDX_BITS   = $clog2(CAPACITY);
   localparam int CNT_BITS   = $clog2(CAPACITY + 1);
   localparam int SQ_BITS    = 2 * COORD_BITS;
   localparam int DIST_BITS  = 49;
   localparam int TGT_BITS   = 11;
   localparam int RIDX_BITS  = 10;
   localparam int CSR_IDX_BITS = 1;

   localparam logic [DIST_BITS-1:0] MIN_DIST_RESET = DIST_BITS'(262144);
   localparam logic [TGT_BITS-1:0]  TARGET_RESET   = TGT_BITS'(1024);

   // request opcodes
   localparam logic [1:0] OP_OFFER = 2'd0;
   localparam logic [1:0] OP_READ  = 2'd1;
   localparam logic [1:0] OP_CLEAR = 2'd2;
   localparam logic [1:0] OP_NONE  = 2'd3;

   // response status codes
   localparam logic [2:0] STAT_ACCEPTED = 3'd0;
   localparam logic [2:0] STAT_OVERLAP  = 3'd1;
   localparam logic [2:0] STAT_FULL     = 3'd2;
   localparam logic [2:0] STAT_READ_OK  = 3'd3;
   localparam logic [2:0] STAT_BEYOND   = 3'd4;
   localparam logic [2:0] STAT_CLEARED  = 3'd5;

   // csr register indexes
   localparam logic [CSR_IDX_BITS-1:0] REG_MIN_DIST = 1'b0;
   localparam logic [CSR_IDX_BITS-1:0] REG_TARGET   = 1'b1;

   typedef struct packed {
      logic load;       // capture request word
      logic scan_init;  // restart scan index
      logic scan_step;  // issue one store read into the distance pipe
      logic respond;    // commit result and present response word
   } ctrl_cmd_type;

   typedef struct packed {
      logic [1:0] op;
      logic       full;
      logic       empty;
      logic       scan_last;
      logic       pipe_busy;
   } dp_status_type;

endpackage

FILE: rtl/core/npp_ctrl.sv
`timescale 1ns / 1ps
// controller state machine for the disk placement block
// depends on npp_pkg

module npp_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  logic [1:0]             req_opcode,
   input  npp_pkg::dp_status_type dp_status,
   output npp_pkg::ctrl_cmd_type  dp_cmd,
   output logic                   busy
);
   import npp_pkg::*;

   typedef enum logic [4:0] {
      ST_IDLE     = 5'b00001,
      ST_DISPATCH = 5'b00010,
      ST_SCAN     = 5'b00100,
      ST_DRAIN    = 5'b01000,
      ST_DONE     = 5'b10000
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      dp_cmd   = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (start && (req_opcode != OP_NONE)) begin
               dp_cmd.load = 1'b1;
               state_in    = ST_DISPATCH;
            end
         end
         ST_DISPATCH: begin
            if ((dp_status.op == OP_OFFER) && !dp_status.full && !dp_status.empty) begin
               dp_cmd.scan_init = 1'b1;
               state_in         = ST_SCAN;
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_SCAN: begin
            dp_cmd.scan_step = 1'b1;
            if (dp_status.scan_last) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (!dp_status.pipe_busy) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            dp_cmd.respond = 1'b1;
            state_in       = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy = (state_ff != ST_IDLE);

endmodule

FILE: rtl/core/npp_datapath.sv
`timescale 1ns / 1ps
// datapath: centre store, csr registers, distance pipe and response registers
// depends on npp_pkg

module npp_datapath (
   input  logic                                clock,
   input  logic                                reset,
   input  npp_pkg::ctrl_cmd_type               dp_cmd,
   output npp_pkg::dp_status_type              dp_status,
   input  logic [1:0]                          req_opcode,
   input  logic [npp_pkg::COORD_BITS-1:0]      req_cand_x,
   input  logic [npp_pkg::COORD_BITS-1:0]      req_cand_y,
   input  logic [npp_pkg::RIDX_BITS-1:0]       req_read_index,
   input  logic                                csr_write,
   input  logic [npp_pkg::CSR_IDX_BITS-1:0]    csr_index,
   input  logic [npp_pkg::DIST_BITS-1:0]       csr_wdata,
   output logic                                rsp_strobe,
   output logic [2:0]                          rsp_status,
   output logic [npp_pkg::CNT_BITS-1:0]        rsp_placed_total,
   output logic [npp_pkg::COORD_BITS-1:0]      rsp_out_x,
   output logic [npp_pkg::COORD_BITS-1:0]      rsp_out_y
);
   import npp_pkg::*;

   // csr registers
   logic [DIST_BITS-1:0] min_dist_ff;
   logic [TGT_BITS-1:0]  target_ff;

   // captured request
   logic [1:0]            op_ff;
   logic [COORD_BITS-1:0] cx_ff, cy_ff;
   logic [IDX_BITS-1:0]   idx_ff;

   logic [CNT_BITS-1:0]   count_ff, count_in;
   logic [CNT_BITS-1:0]   limit;
   logic [IDX_BITS-1:0]   scan_ff;
   logic [IDX_BITS-1:0]   rd_addr;
   logic                  mem_we;

   logic [COORD_BITS-1:0] mem_x [CAPACITY];
   logic [COORD_BITS-1:0] mem_y [CAPACITY];
   logic [COORD_BITS-1:0] rd_x_ff, rd_y_ff;

   // distance pipe
   logic                  va_ff, vb_ff, vc_ff;
   logic [COORD_BITS-1:0] dx_ff, dy_ff;
   logic [SQ_BITS-1:0]    dxsq_ff, dysq_ff;
   logic [DIST_BITS-1:0]  d2;
   logic                  overlap_ff;

   logic [2:0]            status_in;
   logic [COORD_BITS-1:0] out_x_in, out_y_in;
   logic                  rsp_strobe_ff;
   logic [2:0]            rsp_status_ff;
   logic [CNT_BITS-1:0]   rsp_total_ff;
   logic [COORD_BITS-1:0] rsp_x_ff, rsp_y_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         min_dist_ff <= MIN_DIST_RESET;
         target_ff   <= TARGET_RESET;
      end else if (csr_write) begin
         unique case (csr_index)
            REG_MIN_DIST: min_dist_ff <= csr_wdata;
            REG_TARGET:   target_ff   <= csr_wdata[TGT_BITS-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (dp_cmd.load) begin
         op_ff  <= req_opcode;
         cx_ff  <= req_cand_x;
         cy_ff  <= req_cand_y;
         idx_ff <= req_read_index[IDX_BITS-1:0];
      end
   end

   assign limit = (target_ff > TGT_BITS'(CAPACITY)) ? CNT_BITS'(CAPACITY)
                                                   : CNT_BITS'(target_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         scan_ff <= '0;
      end else if (dp_cmd.scan_init) begin
         scan_ff <= '0;
      end else if (dp_cmd.scan_step) begin
         scan_ff <= scan_ff + IDX_BITS'(1);
      end
   end

   assign rd_addr = dp_cmd.scan_step ? scan_ff : idx_ff;

   // store: one write port at the append slot, one registered read port
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem_x[count_ff[IDX_BITS-1:0]] <= cx_ff;
         mem_y[count_ff[IDX_BITS-1:0]] <= cy_ff;
      end
      rd_x_ff <= mem_x[rd_addr];
      rd_y_ff <= mem_y[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         va_ff <= 1'b0;
         vb_ff <= 1'b0;
         vc_ff <= 1'b0;
      end else begin
         va_ff <= dp_cmd.scan_step;
         vb_ff <= va_ff;
         vc_ff <= vb_ff;
      end
   end

   always_ff @(posedge clock) begin
      dx_ff   <= (cx_ff >= rd_x_ff) ? (cx_ff - rd_x_ff) : (rd_x_ff - cx_ff);
      dy_ff   <= (cy_ff >= rd_y_ff) ? (cy_ff - rd_y_ff) : (rd_y_ff - cy_ff);
      dxsq_ff <= dx_ff * dx_ff;
      dysq_ff <= dy_ff * dy_ff;
   end

   assign d2 = DIST_BITS'(dxsq_ff) + DIST_BITS'(dysq_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         overlap_ff <= 1'b0;
      end else if (dp_cmd.load) begin
         overlap_ff <= 1'b0;
      end else if (vc_ff && (d2 < min_dist_ff)) begin
         overlap_ff <= 1'b1;
      end
   end

   // result decision
   always_comb begin
      status_in = STAT_BEYOND;
      count_in  = count_ff;
      mem_we    = 1'b0;
      out_x_in  = '0;
      out_y_in  = '0;
      case (op_ff)
         OP_OFFER: begin
            if (count_ff >= limit) begin
               status_in = STAT_FULL;
            end else if (overlap_ff) begin
               status_in = STAT_OVERLAP;
            end else begin
               status_in = STAT_ACCEPTED;
               mem_we    = dp_cmd.respond;
               count_in  = count_ff + CNT_BITS'(1);
            end
         end
         OP_READ: begin
            if (CNT_BITS'(idx_ff) < count_ff) begin
               status_in = STAT_READ_OK;
               out_x_in  = rd_x_ff;
               out_y_in  = rd_y_ff;
            end
         end
         OP_CLEAR: begin
            status_in = STAT_CLEARED;
            count_in  = '0;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (dp_cmd.respond) begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= dp_cmd.respond;
      end
   end

   always_ff @(posedge clock) begin
      if (dp_cmd.respond) begin
         rsp_status_ff <= status_in;
         rsp_total_ff  <= count_in;
         rsp_x_ff      <= out_x_in;
         rsp_y_ff      <= out_y_in;
      end
   end

   assign dp_status.op        = op_ff;
   assign dp_status.full      = (count_ff >= limit);
   assign dp_status.empty     = (count_ff == '0);
   assign dp_status.scan_last = (CNT_BITS'(scan_ff) == (count_ff - CNT_BITS'(1)));
   assign dp_status.pipe_busy = va_ff | vb_ff | vc_ff;

   assign rsp_strobe       = rsp_strobe_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_placed_total = rsp_total_ff;
   assign rsp_out_x        = rsp_x_ff;
   assign rsp_out_y        = rsp_y_ff;

endmodule

FILE: rtl/core/nonoverlap_point_placement.sv
`timescale 1ns / 1ps
// top level of the disk placement block: controller plus datapath
// depends on npp_pkg, npp_ctrl, npp_datapath

// A request word is taken when start is high and busy is low; every request
// except opcode 3 gives exactly one response word, shown for one cycle with
// rsp_strobe high, and the receiver cannot stall it. Read and clear go from
// dispatch straight to the response. An offer scans all N stored centres only
// when the store is neither empty nor full (so N is at most 1023): the store
// has one read port, so one stored centre is fetched per cycle and fed to a
// four-stage distance pipe (read, abs difference, squares, add and compare),
// which is drained before the decision. busy drops in the strobe cycle, so
// the next request can be taken while the previous response is shown.
// Configuration writes are accepted at any time (csr_ready is tied high)
// and should only be issued while busy is low. Opcode 3 is taken and ignored.

module nonoverlap_point_placement (
   input  logic                             clock,
   input  logic                             reset,
   // request channel
   input  logic                             start,
   output logic                             busy,
   input  logic [1:0]                       req_opcode,
   input  logic [npp_pkg::COORD_BITS-1:0]   req_cand_x,
   input  logic [npp_pkg::COORD_BITS-1:0]   req_cand_y,
   input  logic [npp_pkg::RIDX_BITS-1:0]    req_read_index,
   // response channel
   output logic                             rsp_strobe,
   output logic [2:0]                       rsp_status,
   output logic [npp_pkg::CNT_BITS-1:0]     rsp_placed_total,
   output logic [npp_pkg::COORD_BITS-1:0]   rsp_out_x,
   output logic [npp_pkg::COORD_BITS-1:0]   rsp_out_y,
   // csr write channel
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [npp_pkg::CSR_IDX_BITS-1:0] csr_index,
   input  logic [npp_pkg::DIST_BITS-1:0]    csr_wdata
);
   import npp_pkg::*;

   ctrl_cmd_type  dp_cmd;
   dp_status_type dp_status;

   // registers are plain flops, a write never waits
   assign csr_ready = 1'b1;

   npp_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .req_opcode (req_opcode),
      .dp_status  (dp_status),
      .dp_cmd     (dp_cmd),
      .busy       (busy)
   );

   npp_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .dp_cmd           (dp_cmd),
      .dp_status        (dp_status),
      .req_opcode       (req_opcode),
      .req_cand_x       (req_cand_x),
      .req_cand_y       (req_cand_y),
      .req_read_index   (req_read_index),
      .csr_write        (csr_valid && csr_ready),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .rsp_strobe       (rsp_strobe),
      .rsp_status       (rsp_status),
      .rsp_placed_total (rsp_placed_total),
      .rsp_out_x        (rsp_out_x),
      .rsp_out_y        (rsp_out_y)
   );

endmodule

FILE: rtl/core/npp_checker.sv
`timescale 1ns / 1ps
// port-level assertions for the disk placement block, bound to the top level
// depends on npp_pkg and nonoverlap_point_placement

module npp_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             start,
   input logic                             busy,
   input logic [1:0]                       req_opcode,
   input logic                             rsp_strobe,
   input logic [2:0]                       rsp_status,
   input logic [npp_pkg::CNT_BITS-1:0]     rsp_placed_total,
   input logic [npp_pkg::COORD_BITS-1:0]   rsp_out_x,
   input logic [npp_pkg::COORD_BITS-1:0]   rsp_out_y
);
   import npp_pkg::*;

   // a taken request with a real opcode keeps the block busy next cycle
   a_busy_after_start: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && (req_opcode != OP_NONE)) |=> busy)
      else $error("busy not raised after request");

   // responses never come back to back
   a_no_double_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe)
      else $error("two responses in a row");

   // the block is free again when its response is shown
   a_idle_on_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> !busy)
      else $error("busy during response");

   // coordinates only come with a successful read
   a_zero_coords: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && (rsp_status != STAT_READ_OK)) |-> ((rsp_out_x == '0) && (rsp_out_y == '0)))
      else $error("coordinates on non-read response");

   // an accepted centre leaves at least one stored, a clear leaves none
   a_total_sane: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (((rsp_status == STAT_ACCEPTED) && (rsp_placed_total != '0))
                   || ((rsp_status == STAT_CLEARED) && (rsp_placed_total == '0))
                   || (rsp_status == STAT_OVERLAP) || (rsp_status == STAT_FULL)
                   || (rsp_status == STAT_READ_OK) || (rsp_status == STAT_BEYOND)))
      else $error("bad status or total on response");

endmodule

bind nonoverlap_point_placement npp_checker u_npp_checker (.*);

FILE: test/nonoverlap_point_placement_tb.sv
`timescale 1ns / 1ps
// self-checking bench for the disk placement block: directed and random request words,
// csr writes between phases, an in-bench placement predictor and a response checker
// depends on npp_pkg and nonoverlap_point_placement

module nonoverlap_point_placement_tb;
   import npp_pkg::*;

   localparam int TOTAL_WORDS   = 580;  // request words to generate, ignored opcode excluded
   localparam int TAIL_START    = 520;  // from here on no random idle bursts are added
   localparam int SETTLE_CYCLES = 16;   // quiet cycles after a pause, covers ignored words
   localparam int DRAIN_CYCLES  = 40;   // quiet cycles before the verdict

   typedef enum logic [1:0] {ENT_WORD, ENT_CSR, ENT_PAUSE} ent_kind_type;

   // one entry of the sender's work list
   typedef struct {
      ent_kind_type              kind;
      logic [1:0]                op;
      logic [COORD_BITS-1:0]     x;
      logic [COORD_BITS-1:0]     y;
      logic [RIDX_BITS-1:0]      idx;
      int                        gap;
      logic [CSR_IDX_BITS-1:0]   reg_idx;
      logic [DIST_BITS-1:0]      wdata;
   } pending_op_type;

   // one expected response word
   typedef struct packed {
      logic [2:0]            status;
      logic [CNT_BITS-1:0]   total;
      logic [COORD_BITS-1:0] x;
      logic [COORD_BITS-1:0] y;
   } placement_rsp_type;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     start = 1'b0;
   logic                     busy;
   logic [1:0]               req_opcode = OP_NONE;
   logic [COORD_BITS-1:0]    req_cand_x = '0;
   logic [COORD_BITS-1:0]    req_cand_y = '0;
   logic [RIDX_BITS-1:0]     req_read_index = '0;
   logic                     rsp_strobe;
   logic [2:0]               rsp_status;
   logic [CNT_BITS-1:0]      rsp_placed_total;
   logic [COORD_BITS-1:0]    rsp_out_x;
   logic [COORD_BITS-1:0]    rsp_out_y;
   logic                     csr_valid = 1'b0;
   logic                     csr_ready;
   logic [CSR_IDX_BITS-1:0]  csr_index = '0;
   logic [DIST_BITS-1:0]     csr_wdata = '0;

   // predictor state: stored centres, count and the two registers
   logic [COORD_BITS-1:0]    placed_x [CAPACITY];
   logic [COORD_BITS-1:0]    placed_y [CAPACITY];
   int unsigned              placed_count = 0;
   logic [DIST_BITS-1:0]     gap_sq_min   = MIN_DIST_RESET;
   logic [TGT_BITS-1:0]      target_limit = TARGET_RESET;

   pending_op_type           pending_ops [$];
   placement_rsp_type        expected_rsp [$];

   // handshake flags seen at the last rising edge
   logic                     word_taken = 1'b0;
   logic                     csr_taken  = 1'b0;

   int                       gap_left    = 0;
   int                       settle_left = 0;
   int                       fail_count  = 0;
   int                       words_made  = 0;

   nonoverlap_point_placement u_top (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_opcode       (req_opcode),
      .req_cand_x       (req_cand_x),
      .req_cand_y       (req_cand_y),
      .req_read_index   (req_read_index),
      .rsp_strobe       (rsp_strobe),
      .rsp_status       (rsp_status),
      .rsp_placed_total (rsp_placed_total),
      .rsp_out_x        (rsp_out_x),
      .rsp_out_y        (rsp_out_y),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   always #2 clock = ~clock;

   // ---------------------------------------------------------------------
   // placement predictor: works out the response to one accepted word and
   // updates the predicted store; the unused opcode leaves everything alone
   // ---------------------------------------------------------------------
   task automatic predict_placement(input logic [1:0] op,
                                    input logic [COORD_BITS-1:0] cx,
                                    input logic [COORD_BITS-1:0] cy,
                                    input logic [RIDX_BITS-1:0] ridx);
      placement_rsp_type rsp;
      longint unsigned  dx;
      longint unsigned  dy;
      longint unsigned  d2;
      int unsigned      room;
      bit               hit;
      rsp = '0;
      hit = 1'b0;
      case (op)
         OP_OFFER: begin
            // target above capacity is clamped, target of zero refuses all
            room = (target_limit > CAPACITY) ? CAPACITY : target_limit;
            if (placed_count >= room) begin
               rsp.status = STAT_FULL;
            end else begin
               for (int j = 0; j < placed_count; j++) begin
                  dx = (cx >= placed_x[j]) ? cx - placed_x[j] : placed_x[j] - cx;
                  dy = (cy >= placed_y[j]) ? cy - placed_y[j] : placed_y[j] - cy;
                  d2 = dx * dx + dy * dy;
                  // a distance exactly on the limit still fits
                  if (d2 < gap_sq_min)
                     hit = 1'b1;
               end
               if (hit) begin
                  rsp.status = STAT_OVERLAP;
               end else begin
                  placed_x[placed_count] = cx;
                  placed_y[placed_count] = cy;
                  placed_count++;
                  rsp.status = STAT_ACCEPTED;
               end
            end
         end
         OP_READ: begin
            if (ridx < placed_count) begin
               rsp.status = STAT_READ_OK;
               rsp.x      = placed_x[ridx];
               rsp.y      = placed_y[ridx];
            end else begin
               rsp.status = STAT_BEYOND;
            end
         end
         OP_CLEAR: begin
            // only the count goes back to zero, the entries stay
            placed_count = 0;
            rsp.status   = STAT_CLEARED;
         end
         default: return;
      endcase
      rsp.total = CNT_BITS'(placed_count);
      expected_rsp.push_back(rsp);
   endtask

   // ---------------------------------------------------------------------
   // driver: inputs change on the falling edge, one work-list entry at a time
   // ---------------------------------------------------------------------
   always @(negedge clock) begin
      pending_op_type head;
      logic        next_start;
      logic        next_csr;
      next_start = start;
      next_csr   = csr_valid;
      if (!reset) begin
         // drop valid once the last rising edge took the word
         if (start && word_taken)
            next_start = 1'b0;
         if (csr_valid && csr_taken)
            next_csr = 1'b0;
         if (!next_start && !next_csr) begin
            if (gap_left > 0) begin
               gap_left--;
            end else if (settle_left > 0) begin
               settle_left--;
            end else if (pending_ops.size() > 0) begin
               head = pending_ops[0];
               if (head.kind == ENT_PAUSE) begin
                  // hold off until every response is back and the block is idle
                  if (expected_rsp.size() == 0 && !busy) begin
                     settle_left = SETTLE_CYCLES;
                     void'(pending_ops.pop_front());
                  end
               end else if (head.gap > 0) begin
                  // this cycle is the first of the idle burst
                  gap_left = head.gap - 1;
                  pending_ops[0].gap = 0;
               end else begin
                  void'(pending_ops.pop_front());
                  if (head.kind == ENT_WORD) begin
                     req_opcode     <= head.op;
                     req_cand_x     <= head.x;
                     req_cand_y     <= head.y;
                     req_read_index <= head.idx;
                     next_start      = 1'b1;
                  end else begin
                     csr_index <= head.reg_idx;
                     csr_wdata <= head.wdata;
                     next_csr   = 1'b1;
                  end
               end
            end
         end
      end
      start     <= next_start;
      csr_valid <= next_csr;
   end

   // ---------------------------------------------------------------------
   // monitor: sampled on the rising edge; responses are checked before the
   // word taken at the same edge is predicted
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      placement_rsp_type want;
      if (reset) begin
         word_taken <= 1'b0;
         csr_taken  <= 1'b0;
      end else begin
         word_taken <= start && !busy;
         csr_taken  <= csr_valid && csr_ready;
         if (rsp_strobe) begin
            if (expected_rsp.size() == 0) begin
               $error("response word with none pending: status %0d total %0d",
                      rsp_status, rsp_placed_total);
               fail_count++;
            end else begin
               want = expected_rsp.pop_front();
               if (rsp_status !== want.status) begin
                  $error("status: expected %0d, got %0d", want.status, rsp_status);
                  fail_count++;
               end
               if (rsp_placed_total !== want.total) begin
                  $error("placed_total: expected %0d, got %0d", want.total,
                         rsp_placed_total);
                  fail_count++;
               end
               if (rsp_out_x !== want.x) begin
                  $error("out_x: expected %h, got %h", want.x, rsp_out_x);
                  fail_count++;
               end
               if (rsp_out_y !== want.y) begin
                  $error("out_y: expected %h, got %h", want.y, rsp_out_y);
                  fail_count++;
               end
            end
         end
         if (csr_valid && csr_ready) begin
            if (csr_index == REG_MIN_DIST)
               gap_sq_min = csr_wdata;
            else
               target_limit = csr_wdata[TGT_BITS-1:0];
         end
         if (start && !busy)
            predict_placement(req_opcode, req_cand_x, req_cand_y, req_read_index);
      end
   end

   // ---------------------------------------------------------------------
   // work-list builders
   // ---------------------------------------------------------------------
   task automatic add_word(input logic [1:0] op, input logic [COORD_BITS-1:0] x,
                          input logic [COORD_BITS-1:0] y,
                          input logic [RIDX_BITS-1:0] idx, input bit idle_ok);
      pending_op_type ent;
      ent = '{kind: ENT_WORD, default: '0};
      ent.kind = ENT_WORD;
      ent.op   = op;
      ent.x    = x;
      ent.y    = y;
      ent.idx  = idx;
      // random idle bursts, none in the tail of the run
      if (idle_ok && words_made < TAIL_START && $urandom_range(0, 3) == 0)
         ent.gap = $urandom_range(1, 14);
      pending_ops.push_back(ent);
      if (op != OP_NONE)
         words_made++;
   endtask

   task automatic add_csr(input logic [CSR_IDX_BITS-1:0] reg_idx,
                         input logic [DIST_BITS-1:0] data);
      pending_op_type ent;
      ent = '{kind: ENT_CSR, default: '0};
      ent.kind    = ENT_CSR;
      ent.reg_idx = reg_idx;
      ent.wdata   = data;
      pending_ops.push_back(ent);
   endtask

   task automatic add_pause();
      pending_op_type ent;
      ent = '{kind: ENT_PAUSE, default: '0};
      ent.kind = ENT_PAUSE;
      pending_ops.push_back(ent);
   endtask

   function automatic logic [COORD_BITS-1:0] clamp_coord(input longint v);
      if (v < 0)
         return '0;
      if (v > longint'({COORD_BITS{1'b1}}))
         return {COORD_BITS{1'b1}};
      return v[COORD_BITS-1:0];
   endfunction

   // ---------------------------------------------------------------------
   // stimulus, end of run and verdict
   // ---------------------------------------------------------------------
   initial begin
      logic [COORD_BITS-1:0] phase_x [$];
      logic [COORD_BITS-1:0] phase_y [$];
      logic [COORD_BITS-1:0] cx;
      logic [COORD_BITS-1:0] cy;
      logic [DIST_BITS-1:0]  md;
      logic [TGT_BITS-1:0]   tgt;
      longint                radius;
      longint                base_x;
      longint                base_y;
      int                    phase;
      int                    n_words;
      int                    pick;
      bit                    bulk;

      // directed part, reset values: squared diameter 512^2 as an unsigned Q49.0 integer, target 1024
      add_word(OP_READ, '0, '0, '0, 0);                   // read on an empty store
      add_word(OP_OFFER, '0, '0, '0, 0);                  // first offer always fits
      add_word(OP_OFFER, '1, '1, '0, 0);                  // far corner
      add_word(OP_OFFER, 24'd512, '0, '0, 0);             // exactly on the limit
      add_word(OP_OFFER, 24'd511, 24'd1, '0, 0);          // just inside the limit
      add_word(OP_OFFER, '1, 24'hFFFE00, '0, 0);          // just inside, far corner
      add_word(OP_READ, '0, '0, 10'd0, 0);
      add_word(OP_READ, '0, '0, 10'd1, 0);
      add_word(OP_READ, '0, '0, 10'd2, 0);
      add_word(OP_READ, '0, '0, 10'd3, 0);                // one past the last entry
      add_word(OP_READ, '0, '0, '1, 0);                   // top index
      add_word(OP_NONE, '1, '1, '1, 0);                   // unused opcode, ignored
      add_word(OP_CLEAR, '0, '0, '0, 0);
      add_word(OP_READ, '0, '0, 10'd0, 0);                // entry kept but invalid
      add_pause();
      // zero diameter accepts coincident centres; target of two fills up
      add_csr(REG_TARGET, DIST_BITS'(2));
      add_csr(REG_MIN_DIST, '0);
      add_word(OP_OFFER, 24'd5, 24'd5, '0, 0);
      add_word(OP_OFFER, 24'd5, 24'd5, '0, 0);
      add_word(OP_OFFER, 24'd9, 24'd9, '0, 0);            // store full
      add_pause();
      // target of zero refuses every offer, even on an empty store
      add_csr(REG_TARGET, '0);
      add_word(OP_OFFER, 24'd100, 24'd100, '0, 0);
      add_word(OP_CLEAR, '0, '0, '0, 0);
      add_word(OP_OFFER, 24'd100, 24'd100, '0, 0);
      add_pause();
      // largest diameter: nothing fits next to a stored centre; target above capacity
      add_csr(REG_MIN_DIST, '1);
      add_csr(REG_TARGET, DIST_BITS'(11'h7FF));
      add_word(OP_OFFER, '0, '0, '0, 0);
      add_word(OP_OFFER, '1, '0, '0, 0);
      add_word(OP_OFFER, '1, '1, '0, 0);

      // random phases: quiet the block, reprogram, then a burst of words
      phase = 0;
      while (words_made < TOTAL_WORDS) begin
         add_pause();
         bulk   = (phase == 3);
         radius = $urandom_range(1, 1 << $urandom_range(0, 14));
         case ($urandom_range(0, 7))
            0:       md = '0;
            1:       md = '1;
            2:       md = DIST_BITS'({$urandom, $urandom});
            default: md = DIST_BITS'(radius * radius);
         endcase
         case ($urandom_range(0, 9))
            0:       tgt = '0;
            1:       tgt = TGT_BITS'(CAPACITY);
            2:       tgt = '1;
            default: tgt = TGT_BITS'($urandom_range(1, 40));
         endcase
         if (bulk) begin
            // one long phase lets the store grow large
            radius = 4;
            md     = DIST_BITS'(16);
            tgt    = TGT_BITS'(CAPACITY);
         end
         if ($urandom_range(0, 1) == 0) begin
            add_csr(REG_MIN_DIST, md);
            add_csr(REG_TARGET, DIST_BITS'(tgt));
         end else begin
            add_csr(REG_TARGET, DIST_BITS'(tgt));
            add_csr(REG_MIN_DIST, md);
         end
         phase_x.delete();
         phase_y.delete();
         if (bulk || $urandom_range(0, 3) != 0)
            add_word(OP_CLEAR, '0, '0, '0, 1);
         base_x  = $urandom_range(0, 24'hFFFFFF);
         base_y  = $urandom_range(0, 24'hFFFFFF);
         n_words = bulk ? 160 : $urandom_range(10, 40);
         for (int k = 0; k < n_words && words_made < TOTAL_WORDS; k++) begin
            pick = $urandom_range(0, 99);
            if (bulk)
               pick = (k < 150) ? 0 : 70;
            if (pick < 62) begin
               case ($urandom_range(0, 5))
                  0, 1: begin
                     // near an earlier offer, often overlapping
                     if (phase_x.size() > 0) begin
                        int sel;
                        sel = $urandom_range(0, phase_x.size() - 1);
                        cx = clamp_coord(phase_x[sel] + $urandom_range(0, 4 * radius)
                                         - 2 * radius);
                        cy = clamp_coord(phase_y[sel] + $urandom_range(0, 4 * radius)
                                         - 2 * radius);
                     end else begin
                        cx = clamp_coord(base_x);
                        cy = clamp_coord(base_y);
                     end
                  end
                  2: begin
                     // exactly one radius away along an axis
                     if (phase_x.size() > 0) begin
                        int sel;
                        sel = $urandom_range(0, phase_x.size() - 1);
                        cx = clamp_coord(phase_x[sel] + radius);
                        cy = phase_y[sel];
                     end else begin
                        cx = '1;
                        cy = '0;
                     end
                  end
                  3: begin
                     // anywhere in the coordinate range
                     cx = COORD_BITS'($urandom);
                     cy = COORD_BITS'($urandom);
                  end
                  default: begin
                     // inside the phase's window
                     cx = clamp_coord(base_x + $urandom_range(0, 8 * radius));
                     cy = clamp_coord(base_y + $urandom_range(0, 8 * radius));
                  end
               endcase
               if (bulk) begin
                  cx = COORD_BITS'($urandom);
                  cy = COORD_BITS'($urandom);
               end
               phase_x.push_back(cx);
               phase_y.push_back(cy);
               add_word(OP_OFFER, cx, cy, RIDX_BITS'($urandom), 1);
            end else if (pick < 90) begin
               if ($urandom_range(0, 7) == 0)
                  add_word(OP_READ, COORD_BITS'($urandom), COORD_BITS'($urandom),
                           RIDX_BITS'($urandom), 1);
               else
                  add_word(OP_READ, COORD_BITS'($urandom), COORD_BITS'($urandom),
                           RIDX_BITS'($urandom_range(0, phase_x.size() + 2)), 1);
            end else if (pick < 95) begin
               add_word(OP_CLEAR, COORD_BITS'($urandom), COORD_BITS'($urandom),
                        RIDX_BITS'($urandom), 1);
               phase_x.delete();
               phase_y.delete();
            end else begin
               add_word(OP_NONE, COORD_BITS'($urandom), COORD_BITS'($urandom),
                        RIDX_BITS'($urandom), 1);
            end
         end
         phase++;
      end

      // single reset at the start of the run
      repeat (12) @(negedge clock);
      reset <= 1'b0;

      // wait for the sender to empty its list and every response to come back
      while (pending_ops.size() != 0 || start || csr_valid || expected_rsp.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (fail_count == 0 && expected_rsp.size() == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

   // watchdog, several times the slowest legal run
   initial begin
      #10_000_000;
      $display("Verification failed");
      $finish;
   end

endmodule
